@@ rtl/seven_segment_mux_driver_defines.svh @@
// Assertion macros shared by the checker of the display driver.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef SEVEN_SEGMENT_MUX_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_MUX_DRIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSEG_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSEG_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sseg_pkg.sv @@
package sseg_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_NUMBER = 2'd0;
    localparam t_kind KIND_TEXT   = 2'd1;
    localparam t_kind KIND_RAW    = 2'd2;
    localparam t_kind KIND_TICK   = 2'd3;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DASH  = 8'h40;
    localparam logic [7:0] SEG_UNDER = 8'h08;
    localparam logic [7:0] SEG_DP    = 8'h80;
    localparam logic [7:0] SEG_OVR_0 = 8'h3f;
    localparam logic [7:0] SEG_OVR_V = 8'h3e;
    localparam logic [7:0] SEG_OVR_E = 8'h79;
    localparam logic [7:0] SEG_OVR_R = 8'h50;

    localparam logic signed [15:0] NUM_MAX = 16'sd9999;
    localparam logic signed [15:0] NUM_MIN = -16'sd999;

    // Reciprocal constants: x / 100 = (x * 5243) >> 19 for x below 43699,
    // x / 10 = (x * 103) >> 10 for x below 179.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  DIV10_MUL    = 7'd103;
    localparam int          DIV10_SHIFT  = 10;
    localparam logic [6:0]  DEC_BASE     = 7'd10;
    localparam logic [13:0] DEC_HUNDRED  = 14'd100;

    localparam logic [2:0] DP_MAX     = 3'd4;
    localparam int         SER_BITS   = 16;
    localparam int         SER_CNT_W  = $clog2(SER_BITS + 1);
    localparam logic [3:0] MAX_CHARS  = 4'd4;

    typedef struct packed {
        t_kind             kind;
        logic signed [15:0] number;
        logic [3:0][7:0]   chars;   // index 0 is the first character
        logic [3:0]        len;
    } t_item;

    typedef struct packed {
        t_kind           kind;
        logic [3:0][7:0] chars;
        logic [3:0]      len;
        logic            over;
        logic            under;
        logic            neg;
        logic [3:0]      thou;
        logic [3:0]      hun;
        logic [6:0]      rem;       // magnitude modulo 100
    } t_split;

    typedef struct packed {
        logic        load;
        logic [15:0] word;
    } t_ser_load;

    function automatic logic [7:0] char_seg(input logic [7:0] ch);
        logic [7:0] seg;
        unique case (ch)
            "_": seg = 8'h08;
            "^": seg = 8'h01;
            "-": seg = 8'h40;
            "*": seg = 8'h63;
            " ": seg = 8'h00;
            "A": seg = 8'h77;
            "a": seg = 8'h5f;
            "B", "b": seg = 8'h7c;
            "C": seg = 8'h39;
            "c": seg = 8'h58;
            "D", "d": seg = 8'h5e;
            "E", "e": seg = 8'h79;
            "F", "f": seg = 8'h71;
            "G", "g": seg = 8'h35;
            "H": seg = 8'h76;
            "h": seg = 8'h74;
            "I": seg = 8'h06;
            "i": seg = 8'h04;
            "J": seg = 8'h1e;
            "j": seg = 8'h16;
            "K", "k": seg = 8'h75;
            "L", "l": seg = 8'h38;
            "M", "m": seg = 8'h37;
            "N", "n": seg = 8'h54;
            "O", "o": seg = 8'h5c;
            "P", "p": seg = 8'h73;
            "Q": seg = 8'h7b;
            "q": seg = 8'h67;
            "R", "r": seg = 8'h50;
            "S", "s": seg = 8'h6d;
            "T", "t": seg = 8'h78;
            "U", "u": seg = 8'h1c;
            "V", "v": seg = 8'h3e;
            "W": seg = 8'h7e;
            "w": seg = 8'h2a;
            "X", "x": seg = 8'h76;
            "Y", "y": seg = 8'h6e;
            "Z", "z": seg = 8'h1b;
            "0": seg = 8'h3f;
            "1": seg = 8'h30;
            "2": seg = 8'h5b;
            "3": seg = 8'h4f;
            "4": seg = 8'h66;
            "5": seg = 8'h6d;
            "6": seg = 8'h7d;
            "7": seg = 8'h07;
            "8": seg = 8'h7f;
            "9": seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        return char_seg({4'h3, d});
    endfunction

    // One-hot digit mask of a decimal point position; zero means none.
    function automatic logic [3:0] dp_mask(input logic [2:0] dp);
        logic [3:0] m;
        unique case (dp)
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0010;
            3'd3:    m = 4'b0100;
            3'd4:    m = 4'b1000;
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/sseg_in_if.sv @@
interface sseg_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic signed [15:0] number;
    logic [7:0]        char_first;
    logic [7:0]        char_second;
    logic [7:0]        char_third;
    logic [7:0]        char_fourth;
    logic [3:0]        text_length;

    modport source (
        output valid, kind, number, char_first, char_second, char_third, char_fourth,
               text_length,
        input  ready
    );
    modport sink (
        input  valid, kind, number, char_first, char_second, char_third, char_fourth,
               text_length,
        output ready
    );
endinterface

@@ rtl/sseg_out_if.sv @@
interface sseg_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch;

    modport source (output valid, serial_bit, latch, input ready);
    modport sink (input valid, serial_bit, latch, output ready);
endinterface

@@ rtl/sseg_split.sv @@
module sseg_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sseg_pkg::t_item i_item,
    output logic            o_valid,
    output sseg_pkg::t_split o_split
);
    import sseg_pkg::*;

    // First stage: range check, magnitude and quotient by 100.
    logic        r_a_valid;
    t_kind       r_a_kind;
    logic [3:0][7:0] r_a_chars;
    logic [3:0]  r_a_len;
    logic        r_a_over;
    logic        r_a_under;
    logic        r_a_neg;
    logic [13:0] r_a_mag;
    logic [6:0]  r_a_q;

    logic        neg;
    logic [15:0] mag;
    logic [26:0] prod_q;

    always_comb begin
        neg    = i_item.number[15];
        mag    = neg ? (~i_item.number + 16'd1) : i_item.number;
        prod_q = 27'(mag[13:0]) * 27'(DIV100_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_kind  <= i_item.kind;
            r_a_chars <= i_item.chars;
            r_a_len   <= i_item.len;
            r_a_over  <= i_item.number > NUM_MAX;
            r_a_under <= i_item.number < NUM_MIN;
            r_a_neg   <= neg;
            r_a_mag   <= mag[13:0];
            r_a_q     <= prod_q[DIV100_SHIFT +: 7];
        end
    end

    // Second stage: remainder by 100 and the two upper digits.
    logic        r_b_valid;
    t_split      r_b;
    logic [13:0] rem_full;
    logic [13:0] prod_t;
    logic [3:0]  thou;
    logic [6:0]  hun_full;

    always_comb begin
        rem_full = r_a_mag - 14'(r_a_q) * DEC_HUNDRED;
        prod_t   = 14'(r_a_q) * 14'(DIV10_MUL);
        thou     = prod_t[DIV10_SHIFT +: 4];
        hun_full = r_a_q - 7'(thou) * DEC_BASE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b.kind  <= r_a_kind;
            r_b.chars <= r_a_chars;
            r_b.len   <= r_a_len;
            r_b.over  <= r_a_over;
            r_b.under <= r_a_under;
            r_b.neg   <= r_a_neg;
            r_b.thou  <= thou;
            r_b.hun   <= hun_full[3:0];
            r_b.rem   <= rem_full[6:0];
        end
    end

    assign o_valid = r_b_valid;
    assign o_split = r_b;
endmodule

@@ rtl/sseg_disp.sv @@
module sseg_disp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sseg_pkg::t_split   i_split,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    output sseg_pkg::t_ser_load o_load
);
    import sseg_pkg::*;

    logic [3:0][7:0] r_pat;
    logic [2:0]      r_dp;
    logic [1:0]      r_pos;

    logic [13:0]     prod_t;
    logic [3:0]      ten;
    logic [6:0]      one_full;
    logic [3:0]      one;
    logic [3:0][7:0] num_pat;
    logic [3:0][7:0] txt_pat;
    logic [3:0][7:0] raw_pat;
    logic [3:0][7:0] n_pat;
    logic [3:0]      idx_full;
    logic [2:0]      n_dp;
    logic [3:0]      cfg_mask;
    logic [3:0]      cur_mask;

    always_comb begin
        prod_t   = 14'(i_split.rem) * 14'(DIV10_MUL);
        ten      = prod_t[DIV10_SHIFT +: 4];
        one_full = i_split.rem - 7'(ten) * DEC_BASE;
        one      = one_full[3:0];

        // Leading zeros blank; the minus sign sits left of the top digit.
        num_pat[3] = (i_split.thou == 4'd0) ? SEG_BLANK : digit_seg(i_split.thou);
        num_pat[2] = (i_split.thou == 4'd0 && i_split.hun == 4'd0) ?
                     SEG_BLANK : digit_seg(i_split.hun);
        num_pat[1] = (i_split.thou == 4'd0 && i_split.hun == 4'd0 && ten == 4'd0) ?
                     SEG_BLANK : digit_seg(ten);
        num_pat[0] = digit_seg(one);
        if (i_split.neg) begin
            if (i_split.hun != 4'd0) begin
                num_pat[3] = SEG_DASH;
            end else if (ten != 4'd0) begin
                num_pat[2] = SEG_DASH;
            end else if (one != 4'd0) begin
                num_pat[1] = SEG_DASH;
            end
        end

        idx_full = 4'd0;
        for (int i = 0; i < 4; i++) begin
            idx_full   = i_split.len - 4'(i) - 4'd1;
            txt_pat[i] = (4'(i) < i_split.len) ? char_seg(i_split.chars[idx_full[1:0]])
                                                : SEG_BLANK;
        end
        if (i_split.len > MAX_CHARS) begin
            txt_pat = {SEG_OVR_0, SEG_OVR_V, SEG_OVR_E, SEG_OVR_R};
        end

        for (int i = 0; i < 4; i++) begin
            raw_pat[i] = i_split.chars[3 - i];
        end

        cur_mask = dp_mask(r_dp);
        n_pat    = r_pat;
        unique case (i_split.kind)
            KIND_NUMBER: begin
                if (i_split.over) begin
                    n_pat = {4{SEG_DASH}};
                end else if (i_split.under) begin
                    n_pat = {4{SEG_UNDER}};
                end else begin
                    n_pat = num_pat;
                    for (int i = 0; i < 4; i++) n_pat[i][7] = num_pat[i][7] | cur_mask[i];
                end
            end
            KIND_TEXT: begin
                n_pat = txt_pat;
                for (int i = 0; i < 4; i++) n_pat[i][7] = txt_pat[i][7] | cur_mask[i];
            end
            KIND_RAW: begin
                n_pat = raw_pat;
                for (int i = 0; i < 4; i++) n_pat[i][7] = raw_pat[i][7] | cur_mask[i];
            end
            KIND_TICK: begin
                n_pat = r_pat;
            end
            default: begin
                n_pat = r_pat;
            end
        endcase

        n_dp     = (i_cfg_data > DP_MAX) ? DP_MAX : i_cfg_data;
        cfg_mask = dp_mask(n_dp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_dp  <= 3'd0;
            r_pos <= 2'd0;
        end else if (i_cfg_we) begin
            r_dp <= n_dp;
            for (int i = 0; i < 4; i++) r_pat[i] <= {cfg_mask[i], r_pat[i][6:0]};
        end else if (i_en && i_valid) begin
            if (i_split.kind == KIND_TICK) begin
                r_pos <= r_pos + 2'd1;
            end else begin
                r_pat <= n_pat;
            end
        end
    end

    assign o_load.load = i_en && i_valid && (i_split.kind == KIND_TICK);
    assign o_load.word = {~r_pat[r_pos], 4'b0000, 4'b0001 << r_pos};
endmodule

@@ rtl/sseg_ser.sv @@
module sseg_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sseg_pkg::t_ser_load i_load,
    output logic                o_free,
    sseg_out_if.source          o_ch
);
    import sseg_pkg::*;

    logic [SER_BITS-1:0]  r_word;
    logic [SER_CNT_W-1:0] r_cnt;
    logic                 take;

    assign take   = o_ch.valid && o_ch.ready;
    assign o_free = (r_cnt == '0) || (r_cnt == SER_CNT_W'(1) && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load.load) begin
            r_cnt <= SER_CNT_W'(SER_BITS);
        end else if (take) begin
            r_cnt <= r_cnt - SER_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_word <= i_load.word;
        end else if (take) begin
            r_word <= {r_word[SER_BITS-2:0], 1'b0};
        end
    end

    assign o_ch.valid      = (r_cnt != '0);
    assign o_ch.serial_bit = r_word[SER_BITS-1];
    assign o_ch.latch      = (r_cnt == SER_CNT_W'(1));
endmodule

@@ rtl/seven_segment_mux_driver.sv @@
// Four-digit multiplexed seven-segment driver for two chained shift registers.
// Requests arrive on i_in_ch: a number, up to four text characters, four raw
// segment patterns, or a scan tick. Numbers, text and raw patterns update the
// four stored digit patterns and produce nothing on the output. A scan tick
// produces sixteen output requests on o_out_ch, one bit each, MSB first: the
// inverted segment byte of the current digit, then the one-hot digit byte.
// latch is high on the sixteenth bit. The scan position then advances.
// i_cfg_we with i_cfg_data sets the decimal point digit (1 rightmost to 4
// leftmost, 0 none, larger values act as 4); write it only when idle.
// A request passes three register stages, the input register and the two split
// stages, before it updates the stored patterns or, for a tick, loads the
// shifter. One request is accepted per cycle, except that a tick waits at the
// last stage while the shifter still sends the previous word.
// When the receiver stalls, the current bit holds and requests back up into
// the pipeline until i_in_ch.ready drops. Reset blanks all digits, clears the
// decimal point, sets the scan position to the rightmost digit and empties
// the pipeline.
module seven_segment_mux_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sseg_in_if.sink     i_in_ch,
    sseg_out_if.source  o_out_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data
);
    import sseg_pkg::*;

    logic      r_s1_valid;
    t_item     r_s1;
    logic      split_valid;
    t_split    split;
    t_ser_load ser_load;
    logic      ser_free;
    logic      en;

    // The whole pipeline moves together; it stops only when a tick in the
    // last stage cannot hand its word to the shifter.
    assign en = !(split_valid && split.kind == KIND_TICK && !ser_free);
    assign i_in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.kind   <= i_in_ch.kind;
            r_s1.number <= i_in_ch.number;
            r_s1.chars  <= {i_in_ch.char_fourth, i_in_ch.char_third,
                            i_in_ch.char_second, i_in_ch.char_first};
            r_s1.len    <= i_in_ch.text_length;
        end
    end

    sseg_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_valid),
        .i_item  (r_s1),
        .o_valid (split_valid),
        .o_split (split)
    );

    sseg_disp u_disp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (split_valid),
        .i_split    (split),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_load     (ser_load)
    );

    sseg_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ser_load),
        .o_free  (ser_free),
        .o_ch    (o_out_ch)
    );
endmodule

@@ rtl/sseg_chk.sv @@
`include "seven_segment_mux_driver_defines.svh"

module sseg_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_serial_bit,
    input logic i_latch
);
    logic [3:0] r_bits;
    logic       take;
    logic       stall;
    logic [1:0] out_pair;

    assign take     = i_out_valid && i_out_ready;
    assign stall    = i_out_valid && !i_out_ready;
    assign out_pair = {i_serial_bit, i_latch};

    // Counts the bits of the current word that have been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 4'd0;
        end else if (take) begin
            r_bits <= i_latch ? 4'd0 : r_bits + 4'd1;
        end
    end

    `SSEG_CHK_SAME(a_latch_last, take && i_latch, r_bits == 4'd15, "latch not on sixteenth bit")
    `SSEG_CHK_SAME(a_latch_due, take && !i_latch, r_bits != 4'd15, "sixteenth bit without latch")
    `SSEG_CHK_SAME(a_select_high, take && r_bits[3:2] == 2'b10, !i_serial_bit, "upper select set")
    `SSEG_CHK_NEXT(a_stall_hold, stall, i_out_valid && $stable(out_pair), "stalled bit changed")
endmodule

bind seven_segment_mux_driver sseg_chk u_sseg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_serial_bit (o_out_ch.serial_bit),
    .i_latch      (o_out_ch.latch)
);

@@ verif/seven_segment_mux_driver_tb.sv @@
`timescale 1ns / 100ps

module seven_segment_mux_driver_tb;
    import sseg_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 10;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 50;

    typedef struct packed {
        logic serial_bit;
        logic latch;
    } t_shift_bit;

    // Tracks the four digit patterns, the scan position and the decimal point
    // setting, and holds the serial bits that the accepted scan ticks owe.
    class segment_scoreboard;
        logic [7:0]  glyphs [4];
        logic [1:0]  scan_pos;
        logic [2:0]  dp_sel;
        t_shift_bit  pending_bits [$];
        int          mismatches;

        function new();
            foreach (glyphs[i]) glyphs[i] = SEG_BLANK;
            scan_pos   = 2'd0;
            dp_sel     = 3'd0;
            mismatches = 0;
        endfunction

        function logic [7:0] glyph_of(logic [7:0] ch);
            case (ch)
                "_": return 8'h08;
                "^": return 8'h01;
                "-": return 8'h40;
                "*": return 8'h63;
                "A": return 8'h77;
                "a": return 8'h5f;
                "B", "b": return 8'h7c;
                "C": return 8'h39;
                "c": return 8'h58;
                "D", "d": return 8'h5e;
                "E", "e": return 8'h79;
                "F", "f": return 8'h71;
                "G", "g": return 8'h35;
                "H": return 8'h76;
                "h": return 8'h74;
                "I": return 8'h06;
                "i": return 8'h04;
                "J": return 8'h1e;
                "j": return 8'h16;
                "K", "k": return 8'h75;
                "L", "l": return 8'h38;
                "M", "m": return 8'h37;
                "N", "n": return 8'h54;
                "O", "o": return 8'h5c;
                "P", "p": return 8'h73;
                "Q": return 8'h7b;
                "q": return 8'h67;
                "R", "r": return 8'h50;
                "S", "s": return 8'h6d;
                "T", "t": return 8'h78;
                "U", "u": return 8'h1c;
                "V", "v": return 8'h3e;
                "W": return 8'h7e;
                "w": return 8'h2a;
                "X", "x": return 8'h76;
                "Y", "y": return 8'h6e;
                "Z", "z": return 8'h1b;
                "0": return 8'h3f;
                "1": return 8'h30;
                "2": return 8'h5b;
                "3": return 8'h4f;
                "4": return 8'h66;
                "5": return 8'h6d;
                "6": return 8'h7d;
                "7": return 8'h07;
                "8": return 8'h7f;
                "9": return 8'h6f;
                default: return SEG_BLANK;
            endcase
        endfunction

        function logic [7:0] decimal_glyph(int d);
            return glyph_of(8'h30 + 8'(d));
        endfunction

        function void mark_dp();
            if (dp_sel >= 3'd1 && dp_sel <= DP_MAX) begin
                glyphs[dp_sel - 3'd1] = glyphs[dp_sel - 3'd1] | SEG_DP;
            end
        endfunction

        function void set_dp(logic [2:0] v);
            dp_sel = (v > DP_MAX) ? DP_MAX : v;
            foreach (glyphs[i]) glyphs[i] = glyphs[i] & ~SEG_DP;
            mark_dp();
        endfunction

        function void show_number(logic signed [15:0] n);
            int v;
            int mag;
            v = n;
            if (v > 9999) begin
                foreach (glyphs[i]) glyphs[i] = SEG_DASH;
                return;
            end
            if (v < -999) begin
                foreach (glyphs[i]) glyphs[i] = SEG_UNDER;
                return;
            end
            mag = (v < 0) ? -v : v;
            glyphs[0] = decimal_glyph(mag % 10);
            glyphs[1] = (mag < 10) ? SEG_BLANK : decimal_glyph((mag / 10) % 10);
            glyphs[2] = (mag < 100) ? SEG_BLANK : decimal_glyph((mag / 100) % 10);
            glyphs[3] = (mag < 1000) ? SEG_BLANK : decimal_glyph(mag / 1000);
            // The minus sign takes the blank just left of the leading digit.
            if (v < 0) begin
                if (mag > 99) glyphs[3] = SEG_DASH;
                else if (mag > 9) glyphs[2] = SEG_DASH;
                else glyphs[1] = SEG_DASH;
            end
            mark_dp();
        endfunction

        function void show_text(t_item r);
            int i;
            if (r.len <= MAX_CHARS) begin
                for (i = 0; i < 4; i++) begin
                    glyphs[i] = (i < r.len) ? glyph_of(r.chars[r.len - 1 - i]) : SEG_BLANK;
                end
            end else begin
                glyphs[3] = SEG_OVR_0;
                glyphs[2] = SEG_OVR_V;
                glyphs[1] = SEG_OVR_E;
                glyphs[0] = SEG_OVR_R;
            end
            mark_dp();
        endfunction

        function void note_request(t_item r);
            logic [15:0] word;
            t_shift_bit  b;
            int          i;
            case (r.kind)
                KIND_NUMBER: show_number(r.number);
                KIND_TEXT:   show_text(r);
                KIND_RAW: begin
                    for (i = 0; i < 4; i++) glyphs[3 - i] = r.chars[i];
                    mark_dp();
                end
                default: begin
                    word = {~glyphs[scan_pos], 4'b0000, 4'b0001 << scan_pos};
                    for (i = 0; i < 16; i++) begin
                        b.serial_bit = word[15 - i];
                        b.latch      = (i == 15);
                        pending_bits.push_back(b);
                    end
                    scan_pos = scan_pos + 2'd1;
                end
            endcase
        endfunction

        function void check_bit(logic sbit, logic lat);
            t_shift_bit want;
            if (pending_bits.size() == 0) begin
                $display("%0t: unexpected output: expected nothing, got bit %b latch %b",
                         $time, sbit, lat);
                mismatches++;
                return;
            end
            want = pending_bits.pop_front();
            if (sbit !== want.serial_bit) begin
                $display("%0t: serial_bit expected %b, got %b", $time, want.serial_bit, sbit);
                mismatches++;
            end
            if (lat !== want.latch) begin
                $display("%0t: latch expected %b, got %b", $time, want.latch, lat);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_bits.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [2:0] cfg_data;

    sseg_in_if  in_ch ();
    sseg_out_if out_ch ();

    seven_segment_mux_driver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    segment_scoreboard sb;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    string glyph_chars = "_^-* AaBbCcDdEeFfGgHhIiJjKkLlMmNnOoPpQqRrSsTtUuVvWwXxYyZz0123456789";

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run timed out with %0d serial bits outstanding", $time, sb.outstanding());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output side: checks each accepted bit, then decides ready for the next cycle.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_bit(out_ch.serial_bit, out_ch.latch);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_item make_request(t_kind k, logic signed [15:0] n,
                                           logic [3:0] len, logic [31:0] bytes);
        t_item r;
        r.kind   = k;
        r.number = n;
        r.len    = len;
        r.chars  = {bytes[7:0], bytes[15:8], bytes[23:16], bytes[31:24]};
        return r;
    endfunction

    function automatic t_item random_request();
        t_item r;
        int    pick;
        int    i;
        int    edges [8] = '{9999, 10000, -999, -1000, 0, -1, 32767, -32768};
        r.kind   = t_kind'($urandom_range(0, 3));
        r.number = 16'($urandom);
        r.len    = 4'($urandom);
        r.chars  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r.kind = KIND_TICK;
        end else if (pick < 65) begin
            r.kind = KIND_NUMBER;
            case ($urandom_range(0, 4))
                0: r.number = 16'($urandom);
                1: r.number = 16'(int'($urandom_range(0, 10998)) - 999);
                2: r.number = 16'(int'($urandom_range(0, 198)) - 99);
                3: r.number = 16'(int'($urandom_range(0, 18)) - 9);
                default: r.number = 16'(edges[$urandom_range(0, 7)]);
            endcase
        end else if (pick < 85) begin
            r.kind = KIND_TEXT;
            r.len  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(5, 15))
                                                  : 4'($urandom_range(0, 4));
            for (i = 0; i < 4; i++) begin
                if ($urandom_range(0, 4) != 0) begin
                    r.chars[i] = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
                end
            end
        end else begin
            r.kind = KIND_RAW;
        end
        return r;
    endfunction

    task automatic offer(input t_item r);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= r.kind;
        in_ch.number      <= r.number;
        in_ch.char_first  <= r.chars[0];
        in_ch.char_second <= r.chars[1];
        in_ch.char_third  <= r.chars[2];
        in_ch.char_fourth <= r.chars[3];
        in_ch.text_length <= r.len;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(r);
    endtask

    // Stops offering requests until every owed bit is out, then lets the
    // pipeline empty of requests that owe nothing.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_dp(input logic [2:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_dp(v);
    endtask

    initial begin
        logic [2:0] phase_dp   [PHASES];
        int         phase_gap  [PHASES];
        int         phase_stall[PHASES];
        int         p;
        int         k;
        t_item      tick;

        phase_dp    = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd6, 3'd3};
        phase_gap   = '{10, 10, 87, 87, 0, 0};
        phase_stall = '{87, 87, 10, 10, 0, 0};
        sb = new();
        tick = make_request(KIND_TICK, 16'sd0, 4'd0, 32'h0);
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= 3'd0;
        in_ch.valid       <= 1'b0;
        in_ch.kind        <= KIND_NUMBER;
        in_ch.number      <= 16'sd0;
        in_ch.char_first  <= 8'h00;
        in_ch.char_second <= 8'h00;
        in_ch.char_third  <= 8'h00;
        in_ch.char_fourth <= 8'h00;
        in_ch.text_length <= 4'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_dp(3'd2);
        offer(make_request(KIND_NUMBER, 16'sd10000, 4'd0, 32'h0));
        offer(tick);
        offer(make_request(KIND_NUMBER, -16'sd1000, 4'd0, 32'h0));
        offer(tick);
        offer(make_request(KIND_NUMBER, 16'sd9999, 4'd0, 32'h0));
        offer(make_request(KIND_NUMBER, -16'sd999, 4'd0, 32'h0));
        offer(tick);
        offer(make_request(KIND_NUMBER, 16'sd32767, 4'd0, 32'h0));
        offer(make_request(KIND_NUMBER, -16'sd32768, 4'd0, 32'h0));
        offer(make_request(KIND_NUMBER, 16'sd0, 4'd0, 32'h0));
        offer(tick);
        offer(make_request(KIND_NUMBER, -16'sd5, 4'd0, 32'h0));
        offer(make_request(KIND_NUMBER, -16'sd42, 4'd0, 32'h0));
        offer(tick);
        offer(make_request(KIND_TEXT, 16'sd0, 4'd0, "Abcd"));
        offer(tick);
        offer(make_request(KIND_TEXT, 16'sd0, 4'd4, "-aZ9"));
        offer(tick);
        offer(make_request(KIND_TEXT, 16'sd0, 4'd15, "HELP"));
        offer(tick);
        // Unknown characters, bytes above 127 among them, show blank.
        offer(make_request(KIND_TEXT, 16'sd0, 4'd3, {8'hff, 8'h80, "q!"}));
        offer(tick);
        offer(make_request(KIND_RAW, 16'sd0, 4'd0, 32'hff00807f));
        offer(tick);
        offer(tick);

        for (p = 0; p < PHASES; p++) begin
            write_dp(phase_dp[p]);
            send_gap_pct   = phase_gap[p];
            recv_stall_pct = phase_stall[p];
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 25) drain();
                // A long hold-off on the output while ticks keep coming in.
                if (p == 4 && k == 10) hold_request = 400;
                if (p == 4 && k >= 10 && k < 20) offer(tick);
                else offer(random_request());
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
